[design/exhaustive_open_tour_manhattan_unit_defines.svh]
// Assertion shorthands for the asserting file of the tour unit.
`ifndef EXHAUSTIVE_OPEN_TOUR_MANHATTAN_UNIT_DEFINES_SVH
`define EXHAUSTIVE_OPEN_TOUR_MANHATTAN_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define EOTM_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define EOTM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/eotm_pkg.sv]
package eotm_pkg;

   localparam int DEFAULT_MAX_POINTS = 8;

   localparam int COORD_W    = 8;
   localparam int RANK_W     = 3;
   localparam int INDEX_W    = 3;
   localparam int LEN_W      = 16;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 40;
   localparam int RSP_PAD_W  = RSP_DATA_W - (RANK_W + INDEX_W + 2 * COORD_W + LEN_W);
   localparam int RSP_USER_W = 2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_we;
      logic init;
      logic sum_issue;
      logic sum_first;
      logic compare;
      logic pivot;
      logic swap;
      logic reverse;
      logic rd_best;
      logic out_load;
      logic out_last;
      logic out_empty;
      logic out_overflow;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic has_pivot;
      logic out_free;
   } status_type;

endpackage

[design/eotm_dpath.sv]
module eotm_dpath #(
   parameter int MAX_POINTS = eotm_pkg::DEFAULT_MAX_POINTS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  eotm_pkg::cmd_type                   cmd,
   output eotm_pkg::status_type                status,
   input  logic [$clog2(MAX_POINTS)-1:0]       load_addr,
   input  logic [$clog2(MAX_POINTS)-1:0]       npts,
   input  logic [$clog2(MAX_POINTS)-1:0]       step,
   input  logic [eotm_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                                rsp_tready,
   output logic                                rsp_tvalid,
   output logic [eotm_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic [eotm_pkg::RSP_USER_W-1:0]     rsp_tuser,
   output logic                                rsp_tlast
);

   localparam int IDX_W   = $clog2(MAX_POINTS);
   localparam int ORD     = MAX_POINTS - 1;
   localparam int OIDX_W  = $clog2(ORD);
   localparam int COORD_W = eotm_pkg::COORD_W;
   localparam int LEN_W   = eotm_pkg::LEN_W;
   localparam int RANK_W  = eotm_pkg::RANK_W;
   localparam int INDEX_W = eotm_pkg::INDEX_W;

   // Point store, one write port and one registered read port.
   logic [COORD_W-1:0] row_mem [MAX_POINTS];
   logic [COORD_W-1:0] col_mem [MAX_POINTS];
   logic [COORD_W-1:0] rd_row_ff, rd_col_ff;
   logic [IDX_W-1:0]   rd_addr;

   logic [IDX_W-1:0]   order_ff [ORD];
   logic [IDX_W-1:0]   order_in [ORD];
   logic [IDX_W-1:0]   best_ord_ff [ORD];
   logic [IDX_W-1:0]   path_idx, best_idx;

   logic               has_piv;
   logic [OIDX_W-1:0]  piv_pos, piv_pos_ff;
   logic [IDX_W-1:0]   piv_val, piv_val_ff;
   logic [OIDX_W-1:0]  j_pos;
   logic [IDX_W-1:0]   j_val;

   logic               pend_ff, pend_first_ff;
   logic [COORD_W-1:0] prev_row_ff, prev_col_ff;
   logic [COORD_W-1:0] dr, dc;
   logic [COORD_W:0]   leg;
   logic [LEN_W:0]     sum_wide;
   logic [LEN_W-1:0]   sum_ff, sum_next, best_len_ff;
   logic               have_ff, take;

   logic                                rsp_valid_ff;
   logic [eotm_pkg::RSP_DATA_W-1:0]     rsp_data_ff, rsp_data_in;
   logic [eotm_pkg::RSP_USER_W-1:0]     rsp_user_ff;
   logic                                rsp_last_ff;
   logic [IDX_W-1:0]                    out_idx;
   logic [LEN_W-1:0]                    out_len;

   // Step zero of a path is the start point; step s reads lane s-1 of the order.
   always_comb begin
      path_idx = '0;
      best_idx = '0;
      for (int k = 0; k < ORD; k++) begin
         if (int'(step) == k + 1) path_idx = order_ff[k];
         if (int'(step) == k) best_idx = best_ord_ff[k];
      end
      rd_addr = cmd.rd_best ? best_idx : path_idx;
   end

   always_ff @(posedge clock) begin
      if (cmd.load_we) begin
         row_mem[load_addr] <= req_tdata[COORD_W-1:0];
         col_mem[load_addr] <= req_tdata[2*COORD_W-1:COORD_W];
      end
      rd_row_ff <= row_mem[rd_addr];
      rd_col_ff <= col_mem[rd_addr];
   end

   // Next-permutation pivot: the rightmost ascent among the active lanes.
   always_comb begin
      has_piv = 1'b0;
      piv_pos = '0;
      piv_val = '0;
      for (int k = 1; k < ORD; k++) begin
         if (k < int'(npts) && order_ff[k-1] < order_ff[k]) begin
            has_piv = 1'b1;
            piv_pos = OIDX_W'(k);
         end
      end
      for (int k = 0; k < ORD; k++) begin
         if (k + 1 == int'(piv_pos)) piv_val = order_ff[k];
      end
   end

   // Rightmost lane holding a value above the pivot value.
   always_comb begin
      j_pos = '0;
      j_val = '0;
      for (int k = 0; k < ORD; k++) begin
         if (k < int'(npts) && order_ff[k] > piv_val_ff) begin
            j_pos = OIDX_W'(k);
            j_val = order_ff[k];
         end
      end
   end

   always_comb begin
      int src;
      src = 0;
      order_in = order_ff;
      if (cmd.init) begin
         for (int k = 0; k < ORD; k++) order_in[k] = IDX_W'(k + 1);
      end else if (cmd.swap) begin
         for (int k = 0; k < ORD; k++) begin
            if (k == int'(j_pos)) begin
               order_in[k] = piv_val_ff;
            end else if (k + 1 == int'(piv_pos_ff)) begin
               order_in[k] = j_val;
            end
         end
      end else if (cmd.reverse) begin
         // The suffix after the pivot is turned around by one combinational pass.
         for (int k = 0; k < ORD; k++) begin
            if (k >= int'(piv_pos_ff) && k < int'(npts)) begin
               src = int'(npts) - 1 + int'(piv_pos_ff) - k;
               for (int m = 0; m < ORD; m++) begin
                  if (m == src) order_in[k] = order_ff[m];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      order_ff <= order_in;
      if (cmd.pivot) begin
         piv_pos_ff <= piv_pos;
         piv_val_ff <= piv_val;
      end
   end

   // Path length: the read issued in one cycle is folded in during the next.
   always_comb begin
      dr       = (rd_row_ff > prev_row_ff) ? rd_row_ff - prev_row_ff : prev_row_ff - rd_row_ff;
      dc       = (rd_col_ff > prev_col_ff) ? rd_col_ff - prev_col_ff : prev_col_ff - rd_col_ff;
      leg      = {1'b0, dr} + {1'b0, dc};
      sum_wide = {1'b0, sum_ff} + (LEN_W + 1)'(leg);
      sum_next = sum_wide[LEN_W] ? '1 : sum_wide[LEN_W-1:0];
      take     = !have_ff || (sum_ff < best_len_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
         have_ff <= 1'b0;
      end else begin
         pend_ff <= cmd.sum_issue;
         if (cmd.init) begin
            have_ff <= 1'b0;
         end else if (cmd.compare) begin
            have_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      pend_first_ff <= cmd.sum_first;
      if (pend_ff) begin
         prev_row_ff <= rd_row_ff;
         prev_col_ff <= rd_col_ff;
         sum_ff      <= pend_first_ff ? '0 : sum_next;
      end
      if (cmd.compare && take) begin
         best_len_ff <= sum_ff;
         best_ord_ff <= order_ff;
      end
   end

   // Result register.
   always_comb begin
      out_idx     = cmd.out_empty ? '0 : best_idx;
      out_len     = cmd.out_empty ? '0 : best_len_ff;
      rsp_data_in = {{eotm_pkg::RSP_PAD_W{1'b0}}, out_len, rd_col_ff, rd_row_ff,
                     INDEX_W'(out_idx), RANK_W'(step)};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= {cmd.out_empty, cmd.out_overflow};
         rsp_last_ff <= cmd.out_last;
      end
   end

   assign status.has_pivot = has_piv;
   assign status.out_free  = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

[design/eotm_ctrl.sv]
module eotm_ctrl #(
   parameter int MAX_POINTS = eotm_pkg::DEFAULT_MAX_POINTS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic                          req_tlast,
   input  eotm_pkg::status_type          status,
   output eotm_pkg::cmd_type             cmd,
   output logic [$clog2(MAX_POINTS)-1:0] load_addr,
   output logic [$clog2(MAX_POINTS)-1:0] npts,
   output logic [$clog2(MAX_POINTS)-1:0] step
);

   localparam int IDX_W = $clog2(MAX_POINTS);
   localparam int CNT_W = $clog2(MAX_POINTS + 1);

   typedef enum logic [9:0] {
      S_LOAD   = 10'b00_0000_0001,
      S_INIT   = 10'b00_0000_0010,
      S_SUM    = 10'b00_0000_0100,
      S_SUMEND = 10'b00_0000_1000,
      S_CMP    = 10'b00_0001_0000,
      S_PIVOT  = 10'b00_0010_0000,
      S_SWAP   = 10'b00_0100_0000,
      S_REV    = 10'b00_1000_0000,
      S_EREAD  = 10'b01_0000_0000,
      S_EOUT   = 10'b10_0000_0000
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             drop_ff, drop_in;
   logic             empty_ff, empty_in;
   logic [IDX_W-1:0] npts_ff, npts_in;
   logic [IDX_W-1:0] step_ff, step_in;
   logic [IDX_W-1:0] n_c;
   logic             last_c;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      drop_in  = drop_ff;
      empty_in = empty_ff;
      npts_in  = npts_ff;
      step_in  = step_ff;
      n_c      = '0;
      last_c   = 1'b0;
      cmd      = '0;
      unique case (state_ff)
         S_LOAD: begin
            if (req_tvalid) begin
               if (count_ff < CNT_W'(MAX_POINTS)) begin
                  cmd.load_we = 1'b1;
                  count_in    = count_ff + 1'b1;
                  n_c         = IDX_W'(count_ff);
               end else begin
                  drop_in = 1'b1;
                  n_c     = IDX_W'(MAX_POINTS - 1);
               end
               if (req_tlast) begin
                  npts_in = n_c;
                  step_in = '0;
                  if (n_c == '0) begin
                     empty_in = 1'b1;
                     state_in = S_EREAD;
                  end else begin
                     state_in = S_INIT;
                  end
               end
            end
         end
         S_INIT: begin
            cmd.init = 1'b1;
            step_in  = '0;
            state_in = S_SUM;
         end
         S_SUM: begin
            cmd.sum_issue = 1'b1;
            cmd.sum_first = (step_ff == '0);
            if (step_ff == npts_ff) begin
               state_in = S_SUMEND;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         S_SUMEND: begin
            state_in = S_CMP;
         end
         S_CMP: begin
            cmd.compare = 1'b1;
            state_in    = S_PIVOT;
         end
         S_PIVOT: begin
            cmd.pivot = 1'b1;
            if (status.has_pivot) begin
               state_in = S_SWAP;
            end else begin
               step_in  = '0;
               state_in = S_EREAD;
            end
         end
         S_SWAP: begin
            cmd.swap = 1'b1;
            state_in = S_REV;
         end
         S_REV: begin
            cmd.reverse = 1'b1;
            step_in     = '0;
            state_in    = S_SUM;
         end
         S_EREAD: begin
            cmd.rd_best = !empty_ff;
            state_in    = S_EOUT;
         end
         S_EOUT: begin
            last_c           = empty_ff || (step_ff == npts_ff - 1'b1);
            cmd.rd_best      = !empty_ff;
            cmd.out_empty    = empty_ff;
            cmd.out_overflow = drop_ff;
            cmd.out_last     = last_c;
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               if (last_c) begin
                  count_in = '0;
                  drop_in  = 1'b0;
                  empty_in = 1'b0;
                  state_in = S_LOAD;
               end else begin
                  step_in  = step_ff + 1'b1;
                  state_in = S_EREAD;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         count_ff <= '0;
         drop_ff  <= 1'b0;
         empty_ff <= 1'b0;
         npts_ff  <= '0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         drop_ff  <= drop_in;
         empty_ff <= empty_in;
         npts_ff  <= npts_in;
         step_ff  <= step_in;
      end
   end

   assign req_tready = (state_ff == S_LOAD);
   assign load_addr  = count_ff[IDX_W-1:0];
   assign npts       = npts_ff;
   assign step       = step_ff;

endmodule

[design/exhaustive_open_tour_manhattan_unit.sv]
// Finds the shortest open path over a small set of grid points by trying every
// visiting order. Points arrive one per transfer, one per cycle; the first is the
// fixed start and the transfer with tlast closes the set. Up to MAX_POINTS points
// are kept, later ones are dropped and reported through the overflow flag. While
// the search runs the input is not ready. Orders are walked in lexicographic
// order with a step-by-step next-permutation unit, and each path is summed one
// leg per cycle through the single read port of the point store. The result is
// then sent as one transfer per point visited after the start, each through a
// read state and an output state that waits for the result register to be free;
// a set holding only the start gives one transfer with the empty flag.
`include "exhaustive_open_tour_manhattan_unit_defines.svh"

module exhaustive_open_tour_manhattan_unit #(
   parameter int MAX_POINTS = eotm_pkg::DEFAULT_MAX_POINTS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // point_row[7:0], point_col[15:8]
   input  logic [eotm_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                            req_tlast,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // visit_rank[2:0], visit_index[5:3], visit_row[13:6], visit_col[21:14],
   // tour_length[37:22], zero[39:38]
   output logic [eotm_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // overflow_flag[0], empty_flag[1]
   output logic [eotm_pkg::RSP_USER_W-1:0] rsp_tuser,
   output logic                            rsp_tlast
);

   localparam int IDX_W = $clog2(MAX_POINTS);

   eotm_pkg::cmd_type    cmd;
   eotm_pkg::status_type status;
   logic [IDX_W-1:0]     load_addr;
   logic [IDX_W-1:0]     npts;
   logic [IDX_W-1:0]     step;

   eotm_ctrl #(
      .MAX_POINTS (MAX_POINTS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tlast  (req_tlast),
      .status     (status),
      .cmd        (cmd),
      .load_addr  (load_addr),
      .npts       (npts),
      .step       (step)
   );

   eotm_dpath #(
      .MAX_POINTS (MAX_POINTS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .load_addr  (load_addr),
      .npts       (npts),
      .step       (step),
      .req_tdata  (req_tdata),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // A result is only written into the output register once it is free.
   `EOTM_ASSERT_IMPL(a_no_overwrite, clock, reset, cmd.out_load, status.out_free, "result overwritten")
   // The transfer that closes a set stops input, whether the search or the empty result follows.
   `EOTM_ASSERT_NEXT(a_search_stalls_input, clock, reset, req_tvalid && req_tready && req_tlast, !req_tready, "input open after last point")
   // Results are never produced while points are being loaded.
   `EOTM_ASSERT_IMPL(a_emit_not_loading, clock, reset, cmd.out_load, !req_tready, "result during load")

endmodule
